>>> src/rpg_pkg.sv
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared types, widths and helpers for the RSA power generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpg_pkg;

  // Datapath size
  localparam int MOD_BITS = 16;
  localparam int FIELD_W  = 16;                          // fixed field width
  localparam int NW       = (MOD_BITS < FIELD_W) ? MOD_BITS : FIELD_W;
  localparam int LEN_W    = $clog2(NW + 1);
  localparam int CNT_W    = $clog2(NW);
  localparam int BC_W     = 5;                           // bit_count field
  localparam int EXP_W    = 16;
  localparam int ECNT_W   = $clog2(EXP_W);

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(1);

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_GEN  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] seed_value;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] random_bits;
    logic [BC_W-1:0]    bit_count;
  } out_beat_t;

  // Request into the shared modular multiplier
  typedef struct packed {
    logic          start;
    logic [NW-1:0] a;
    logic [NW-1:0] b;
  } mm_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  // Position of highest set bit plus one; one for zero
  function automatic logic [LEN_W-1:0] bit_len(input logic [NW-1:0] v);
    logic [LEN_W-1:0] len;
    len = LEN_W'(1);
    for (int i = 0; i < NW; i++) begin
      if (v[i]) len = LEN_W'(i + 1);
    end
    return len;
  endfunction

  // Mask with the low len bits set
  function automatic logic [NW-1:0] low_mask(input logic [LEN_W-1:0] len);
    logic [NW-1:0] m;
    for (int i = 0; i < NW; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/rpg_modmul.sv
// ----------------------------------------------------------------------------
// rpg_modmul
// Bit-serial interleaved modular multiplier: a * b mod n, one bit of b a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpg_modmul (
  input  wire                    clk,
  input  wire                    rst_n,
  input  rpg_pkg::mm_req_t       req,
  input  wire [rpg_pkg::NW-1:0]  modulus,
  output logic                   done,
  output logic [rpg_pkg::NW-1:0] result
);
  import rpg_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    a_r, a_nxt;
  logic [NW-1:0]    b_r, b_nxt;
  logic [NW-1:0]    acc_r, acc_nxt;

  logic [NW+1:0]    t;
  logic [NW+1:0]    n1;
  logic [NW+1:0]    n2;
  logic [NW+1:0]    red;

  // acc < n and a < n, so t < 3n: at most one of n or 2n comes off
  always_comb begin
    n1 = (NW+2)'(modulus);
    n2 = (NW+2)'({modulus, 1'b0});
    t  = (NW+2)'({acc_r, 1'b0}) + (b_r[NW-1] ? (NW+2)'(a_r) : '0);
    if (t >= n2) begin
      red = t - n2;
    end else if (t >= n1) begin
      red = t - n1;
    end else begin
      red = t;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NW - 1);
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = red[NW-1:0];
      b_nxt   = {b_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

>>> src/rsa_power_generator_top.sv
// ----------------------------------------------------------------------------
// rsa_power_generator_top
// Micali-Schnorr RSA pseudorandom generator around one shared modmul unit.
// ----------------------------------------------------------------------------
// Write modulus n (index 0) and exponent e (index 1) while the block is idle.
// A load beat (func = 0) stores the seed masked to r = N/2 bits, where N is
// the bit length of n, and yields no result. A generate beat (func = 1)
// computes y = seed^e mod n and returns the low k = N - r bits of y with
// bit_count = k; the top r bits of y become the next seed.
// All arithmetic runs on one bit-serial modular multiplier. A generate beat
// does one product to reduce the seed, then per exponent bit a dispatch
// step, one multiply when that bit is set and one square, and last loads
// the output register; a new beat is taken once the block is idle again.
// A modulus of zero or one returns 0 with bit_count 1 without the multiplier.
// in_stall is high while a generate beat is in work; a finished result
// sits in the output register so the next beat may be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_power_generator_top (
  input  wire                           clk,
  input  wire                           rst_n,
  // config write port
  input  wire                           cfg_we,
  input  wire [rpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [rpg_pkg::FIELD_W-1:0]    cfg_data,
  // input channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  rpg_pkg::in_beat_t             in_data,
  // result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output rpg_pkg::out_beat_t            out_data
);
  import rpg_pkg::*;

  // configuration registers
  logic [NW-1:0]     modulus_r;
  logic [EXP_W-1:0]  exponent_r;

  // sequencer and working values
  state_t            state_r, state_nxt;
  logic [NW-1:0]     seed_r;
  logic [NW-1:0]     x_r;              // running base power
  logic [NW-1:0]     acc_r;            // running product, y at the end
  logic [ECNT_W-1:0] ecnt_r;           // exponent bit in work
  logic              out_valid_r;
  out_beat_t         out_r;

  // derived split of the modulus
  logic [LEN_W-1:0]  nlen;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  klen;
  logic [NW-1:0]     rmask;
  logic [NW-1:0]     kmask;
  logic              n_small;

  logic              in_acc;
  logic              out_free;
  logic              last_bit;

  mm_req_t           mm_req;
  logic              mm_done;
  logic [NW-1:0]     mm_res;

  assign nlen    = bit_len(modulus_r);
  assign rlen    = nlen >> 1;
  assign klen    = nlen - rlen;
  assign rmask   = low_mask(rlen);
  assign kmask   = low_mask(klen);
  assign n_small = (modulus_r[NW-1:1] == '0);   // n is 0 or 1: y is 0

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_bit = (ecnt_r == ECNT_W'(EXP_W - 1));

  rpg_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .modulus (modulus_r),
    .done    (mm_done),
    .result  (mm_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.func == FUNC_GEN)) begin
          state_nxt = n_small ? ST_DONE : ST_RED;
        end
      end
      ST_RED:  if (mm_done) state_nxt = ST_STEP;
      ST_STEP: state_nxt = exponent_r[ecnt_r] ? ST_MUL : ST_SQR;
      ST_MUL:  if (mm_done) state_nxt = ST_SQR;
      ST_SQR: begin
        if (mm_done) state_nxt = last_bit ? ST_DONE : ST_STEP;
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mm_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        // seed mod n, as 1 * seed
        if (in_acc && (in_data.func == FUNC_GEN) && !n_small) begin
          mm_req.start = 1'b1;
          mm_req.a     = NW'(1);
          mm_req.b     = seed_r;
        end
      end
      ST_STEP: begin
        mm_req.start = 1'b1;
        if (exponent_r[ecnt_r]) begin
          mm_req.a = acc_r;
          mm_req.b = x_r;
        end else begin
          mm_req.a = x_r;
          mm_req.b = x_r;
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          mm_req.start = 1'b1;
          mm_req.a     = x_r;
          mm_req.b     = x_r;
        end
      end
      ST_RED, ST_SQR, ST_DONE: mm_req = '0;
      default: mm_req = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= NW'(6);
      exponent_r  <= EXP_W'(1);
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODULUS:  modulus_r  <= cfg_data[NW-1:0];
          CFG_EXPONENT: exponent_r <= EXP_W'(cfg_data);
          default: ;
        endcase
      end

      if (in_acc && (in_data.func == FUNC_LOAD)) begin
        seed_r <= in_data.seed_value[NW-1:0] & rmask;
      end

      if (state_r == ST_DONE && out_free) begin
        seed_r      <= (acc_r >> klen) & rmask;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working values
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.func == FUNC_GEN)) begin
      acc_r  <= '0;
      ecnt_r <= '0;
    end
    if (state_r == ST_RED && mm_done) begin
      x_r   <= mm_res;
      acc_r <= NW'(1);
    end
    if (state_r == ST_MUL && mm_done) begin
      acc_r <= mm_res;
    end
    if (state_r == ST_SQR && mm_done) begin
      x_r    <= mm_res;
      ecnt_r <= ecnt_r + ECNT_W'(1);
    end
    if (state_r == ST_DONE && out_free) begin
      out_r.random_bits <= FIELD_W'(acc_r & kmask);
      out_r.bit_count   <= BC_W'(klen);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> bench/rpg_power_checker.sv
// ----------------------------------------------------------------------------
// rpg_power_checker
// Watches the channels of the RSA power generator and predicts every result.
// ----------------------------------------------------------------------------
// Tracks the modulus, exponent and seed from the observed register writes
// and accepted input beats. Each generate beat queues its expected output
// beat. Output beats are compared in order, one field at a time.
// ----------------------------------------------------------------------------
module rpg_power_checker
  import rpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_beat_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_beat_t            out_data,
  output int                   fails,
  output int                   owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [FIELD_W-1:0] n_reg;
  logic [FIELD_W-1:0] e_reg;
  logic [FIELD_W-1:0] seed_reg;
  out_beat_t          bits_due[$];

  initial begin
    fails = 0;
    owed  = 0;
  end

  // Bit length of the modulus; a zero modulus counts as one bit
  function automatic int mod_length(input logic [FIELD_W-1:0] v);
    int len;
    len = 1;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (v[i]) len = i + 1;
    end
    return len;
  endfunction

  // x^e mod n, square-and-multiply over all sixteen exponent bits
  function automatic logic [31:0] seed_power(input logic [31:0] x,
                                             input logic [15:0] e,
                                             input logic [31:0] n);
    logic [31:0] acc;
    logic [31:0] base;
    if (n < 2) return 32'd0;
    acc  = 32'd1 % n;
    base = x % n;
    for (int i = 0; i < 16; i++) begin
      if (e[i]) acc = (acc * base) % n;
      base = (base * base) % n;
    end
    return acc;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t   want;
    out_beat_t   got;
    logic [31:0] y;
    logic [31:0] rmask;
    logic [31:0] kmask;
    int          nbits;
    int          r;
    int          k;
    if (!rst_n) begin
      n_reg    = 16'd6;
      e_reg    = 16'd1;
      seed_reg = '0;
      bits_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULUS:  n_reg = cfg_data;
          CFG_EXPONENT: e_reg = cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        got = out_data;
        if (bits_due.size() == 0) begin
          $error("unexpected output beat: random_bits %h bit_count %0d",
                 got.random_bits, got.bit_count);
          fails++;
        end else begin
          want = bits_due.pop_front();
          if (got.random_bits !== want.random_bits) begin
            $error("random_bits: expected %h, actual %h", want.random_bits,
                   got.random_bits);
            fails++;
          end
          if (got.bit_count !== want.bit_count) begin
            $error("bit_count: expected %0d, actual %0d", want.bit_count,
                   got.bit_count);
            fails++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        nbits = mod_length(n_reg);
        r     = nbits / 2;
        k     = nbits - r;
        rmask = (32'd1 << r) - 32'd1;
        kmask = (32'd1 << k) - 32'd1;
        if (in_data.func == FUNC_LOAD) begin
          seed_reg = 16'(32'(in_data.seed_value) & rmask);
        end else begin
          y                = seed_power(32'(seed_reg), e_reg, 32'(n_reg));
          want.random_bits = 16'(y & kmask);
          want.bit_count   = BC_W'(k);
          seed_reg         = 16'((y >> k) & rmask);
          bits_due.push_back(want);
        end
      end
    end
    owed = bits_due.size();
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RSA power generator.
// ----------------------------------------------------------------------------
// Runs a short directed set over the register extremes and the corner cases
// (tiny moduli, zero exponent, a seed left above a shrunken modulus), then
// ten random phases of mostly load-then-generate sequences. Both channels
// idle at random; one phase runs without idling and one holds the result
// side off long enough to back the block up. Checking is in the checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpg_pkg::*;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  localparam int QUIET_LIMIT = 20000;  // idle edges before giving up
  localparam int HOLD_CYCLES = 1500;   // long result-side hold-off
  localparam int SETTLE      = 8;      // settling edges before register writes
  localparam int TAIL        = 60;     // extra edges after the last result

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int        fails;
  int        owed;

  // Beats waiting to be offered on the input channel
  in_beat_t  stim_q[$];
  // No random idling on either side while set
  logic      calm = 1'b0;
  // One-shot request for the long hold-off on the result side
  logic      squeeze_req = 1'b0;
  logic      squeeze_done = 1'b0;

  rsa_power_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rpg_power_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .owed      (owed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sender: a new beat may go out once the slot is empty or the held beat
  // was taken at this edge; a stalled beat stays put.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
        in_valid <= 1'b1;
        in_data  <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so the
  // sender keeps pushing until the block backs up and stalls its input.
  initial begin : sink
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 21);
      end
    end
  end

  // Watchdog: any accepted beat on either channel resets the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic void push_load(input logic [FIELD_W-1:0] seed);
    in_beat_t b;
    b.func       = FUNC_LOAD;
    b.seed_value = seed;
    stim_q.push_back(b);
  endfunction

  function automatic void push_gen();
    in_beat_t b;
    b.func       = FUNC_GEN;
    b.seed_value = FIELD_W'($urandom);  // ignored by a generate beat
    stim_q.push_back(b);
  endfunction

  // Sampled at the falling edge so every update of the rising edge is in
  task automatic wait_drained();
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [FIELD_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Registers change only with the block idle; spare indexes get junk
  task automatic set_regs(input logic [FIELD_W-1:0] n,
                          input logic [FIELD_W-1:0] e);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_MODULUS, n);
    write_reg(CFG_EXPONENT, e);
    write_reg(CFG_SPARE_2, FIELD_W'($urandom));
    write_reg(CFG_SPARE_3, FIELD_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0] n_pick;
    logic [FIELD_W-1:0] e_pick;
    int                 count;
    int                 gens;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (n = 6, e = 1); first generate runs on the zero seed
    push_gen();
    push_load(16'hFFFF);
    push_gen();
    push_gen();
    push_load(16'h0000);
    push_gen();

    // Widest modulus, exponent with every bit set
    set_regs(16'hFFFF, 16'hFFFF);
    push_load(16'hFFFF);
    push_gen();
    push_gen();
    push_load(16'h0000);
    push_gen();

    // Modulus zero and one: y forced to 0, bit_count 1
    set_regs(16'h0000, 16'd3);
    push_gen();
    push_load(16'hFFFF);
    push_gen();
    set_regs(16'h0001, 16'h0000);
    push_gen();
    push_load(16'hAAAA);
    push_gen();

    // Zero exponent on a real semiprime: y = 1
    set_regs(16'd3233, 16'h0000);
    push_load(16'h5555);
    push_gen();

    // Load a wide seed, then shrink the modulus under it
    set_regs(16'hFFFF, 16'd3);
    push_load(16'hFFFF);
    set_regs(16'd7, 16'd5);
    push_gen();
    push_gen();

    // Random phases: mostly load followed by a few generates
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(9))
        0:       n_pick = FIELD_W'($urandom_range(6, 63));
        1:       n_pick = 16'hFFFF;
        2:       n_pick = 16'd6;
        3:       n_pick = FIELD_W'($urandom_range(0, 1));
        default: n_pick = FIELD_W'($urandom_range(6, 65535));
      endcase
      case ($urandom_range(9))
        0:       e_pick = 16'h0000;
        1:       e_pick = 16'hFFFF;
        2:       e_pick = 16'h0001;
        default: e_pick = FIELD_W'($urandom_range(1, 65535));
      endcase
      set_regs(n_pick, e_pick);
      calm = (p == 0);

      count = 0;
      while (count < 100) begin
        if ($urandom_range(99) < 85) begin
          push_load(FIELD_W'($urandom));
          gens = $urandom_range(1, 4);
          repeat (gens) push_gen();
          count += gens + 1;
        end else begin
          // stray beat: generate from whatever seed is left, or a bare load
          if ($urandom_range(1) == 1) push_gen();
          else push_load(FIELD_W'($urandom));
          count++;
        end
      end

      if (p == 1) squeeze_req = 1'b1;
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (fails == 0 && owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
